/* design/row_remap_linear_interp_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the row remap block
// Shared concurrent-check forms, all clocked on the rising edge and
// disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ROW_REMAP_LINEAR_INTERP_MACROS_SVH
`define ROW_REMAP_LINEAR_INTERP_MACROS_SVH

// Condition holds at every edge outside reset
`define RRI_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define RRI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define RRI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/rri_pkg.sv */
// ---------------------------------------------------------------------------
// rri_pkg
// Types, field widths, command codes and defaults shared by the row remap
// front end, the item queue and the interpolation back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rri_pkg;

  // Defaults for the top-level parameters
  localparam int ROW_CAPACITY_DEF  = 4096;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed field widths
  localparam int CMD_W        = 2;
  localparam int MAP_INDEX_W  = 12;
  localparam int POSITION_W   = 20;
  localparam int CHANNEL_W    = 8;
  localparam int PIXEL_W      = 3 * CHANNEL_W;
  localparam int MAP_ENTRY_W  = POSITION_W + 1;
  localparam int OUT_COLUMN_W = 12;
  localparam int CONFIG_W     = 13;
  localparam int S_TDATA_W    = 64;
  localparam int M_TDATA_W    = 40;

  // Column field in queue items, wide enough for the largest row capacity
  localparam int COLUMN_W = 13;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CONFIG_W-1:0] ACTIVE_WIDTH_RESET = CONFIG_W'(4096);

  // Command codes carried in s_tuser
  localparam logic [CMD_W-1:0] CMD_MAP_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH    = 2'd2;

  // One classified item handed from the front to the back
  typedef struct packed {
    logic                   map_wr;     // write map_entry at col
    logic                   emit;       // produce an output pixel for col
    logic                   store;      // write pixel into bank at col
    logic                   bank;       // line store currently being written
    logic                   last;       // last column of the row
    logic [COLUMN_W-1:0]    col;        // column, or map index for a load
    logic [MAP_ENTRY_W-1:0] map_entry;  // {valid, position}
    logic [PIXEL_W-1:0]     pixel;      // {red, green, blue}
  } rri_item_t;

  // Back-pressure status seen by the front end
  typedef struct packed {
    logic clearing;    // map clearing pass in progress
    logic queue_full;  // no room for another item
  } rri_status_t;

endpackage

/* design/row_remap_linear_interp.sv */
// ---------------------------------------------------------------------------
// row_remap_linear_interp
// Horizontal distortion correction over RGB rows: a loadable position map
// selects a fractional source column for each output column, and the
// previous row is resampled from a double-buffered line store.
//
//   Channel   Dir  Handshake            Contents
//   s_*       in   s_tvalid / s_tready  command in tuser, map entry or pixel
//   m_*       out  m_tvalid / m_tready  interpolated pixel, column, row end
//   cfg_*     in   cfg_valid/cfg_ready  active_width (13 bits)
//
// One transaction per clock is sustained while the map is not being cleared
// and m_tready is high; a result passes through the queue, the map read,
// the paired line store read and the output register, which holds the blend.
// After reset the position map is cleared one entry a cycle, and s_tready
// stays low until that pass ends; configuration writes are taken always.
// A four-entry queue separates input acceptance from the back end, which
// halts as a whole while a result waits for m_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_remap_linear_interp
  import rri_pkg::*;
#(
  parameter int ROW_CAPACITY  = ROW_CAPACITY_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [11:0] map_index, [12] map_valid, [32:13] map_position,
  // [40:33] pixel_blue, [48:41] pixel_green, [56:49] pixel_red, [63:57] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]     s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] out_blue, [15:8] out_green, [23:16] out_red, [35:24] out_column,
  // [39:36] zero
  output logic [M_TDATA_W-1:0] m_tdata,
  // out_row_end
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CONFIG_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(ROW_CAPACITY + 1);

  logic [CONFIG_W-1:0] active_width;
  logic [CNT_W-1:0]    eff_width;
  rri_status_t         status;
  logic                push;
  rri_item_t           push_item;
  logic                pop;
  logic                head_valid;
  rri_item_t           head_item;
  logic                queue_full;
  logic                clearing;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width <= ACTIVE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_width <= cfg_data;
    end
  end

  // Row width in use: zero acts as one, clamp to capacity
  always_comb begin
    if (active_width == '0) begin
      eff_width = CNT_W'(1);
    end else if ({1'b0, active_width} > (CONFIG_W + 1)'(ROW_CAPACITY)) begin
      eff_width = CNT_W'(ROW_CAPACITY);
    end else begin
      eff_width = CNT_W'(active_width);
    end
  end

  assign status.clearing   = clearing;
  assign status.queue_full = queue_full;

  rri_front #(
    .ROW_CAPACITY (ROW_CAPACITY),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .eff_width (eff_width),
    .status    (status),
    .push      (push),
    .push_item (push_item)
  );

  rri_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .full       (queue_full)
  );

  rri_back #(
    .ROW_CAPACITY  (ROW_CAPACITY),
    .FRACTION_BITS (FRACTION_BITS),
    .CNT_W         (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .eff_width  (eff_width),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .clearing   (clearing),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* design/rri_front.sv */
// ---------------------------------------------------------------------------
// rri_front
// Accepts input transactions, decodes the command, tracks the column
// counter, write bank and row-buffered flag, and pushes one classified item
// per transaction that has any effect.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "row_remap_linear_interp_macros.svh"

module rri_front
  import rri_pkg::*;
#(
  parameter int ROW_CAPACITY = ROW_CAPACITY_DEF,
  parameter int CNT_W        = $clog2(ROW_CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [11:0] map_index, [12] map_valid, [32:13] map_position,
  // [40:33] pixel_blue, [48:41] pixel_green, [56:49] pixel_red, [63:57] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]     s_tuser,
  input  logic [CNT_W-1:0]     eff_width,
  input  rri_status_t          status,
  output logic                 push,
  output rri_item_t            push_item
);

  localparam int COL_W = $clog2(ROW_CAPACITY);
  localparam int IDX_W = COLUMN_W + 1;

  logic [COL_W-1:0]       column_counter;
  logic [COL_W-1:0]       column_counter_next;
  logic                   write_bank;
  logic                   write_bank_next;
  logic                   prev_ready;
  logic                   prev_ready_next;

  logic                   accept;
  logic [MAP_INDEX_W-1:0] map_index;
  logic                   idx_ok;
  logic                   is_row_cmd;
  logic                   last;

  assign s_tready  = !status.clearing && !status.queue_full;
  assign accept    = s_tvalid && s_tready;
  assign map_index = s_tdata[11:0];

  // Classify the transaction
  assign idx_ok     = IDX_W'(map_index) < IDX_W'(ROW_CAPACITY);
  assign is_row_cmd = (s_tuser == CMD_PIXEL) || ((s_tuser == CMD_FLUSH) && prev_ready);
  assign last       = CNT_W'(column_counter) >= (eff_width - CNT_W'(1));

  assign push = accept && (((s_tuser == CMD_MAP_LOAD) && idx_ok) || is_row_cmd);

  // Build the queue item
  always_comb begin
    push_item.map_wr    = (s_tuser == CMD_MAP_LOAD);
    push_item.emit      = is_row_cmd && prev_ready;
    push_item.store     = (s_tuser == CMD_PIXEL);
    push_item.bank      = write_bank;
    push_item.last      = last;
    push_item.col       = (s_tuser == CMD_MAP_LOAD) ? COLUMN_W'(map_index)
                                                    : COLUMN_W'(column_counter);
    push_item.map_entry = {s_tdata[12], s_tdata[32:13]};
    push_item.pixel     = {s_tdata[56:49], s_tdata[48:41], s_tdata[40:33]};
  end

  // Advance the row position on pixels and effective flushes
  always_comb begin
    column_counter_next = column_counter;
    write_bank_next     = write_bank;
    prev_ready_next     = prev_ready;
    if (accept && is_row_cmd) begin
      if (last) begin
        column_counter_next = '0;
        write_bank_next     = !write_bank;
        prev_ready_next     = (s_tuser == CMD_PIXEL);
      end else begin
        column_counter_next = column_counter + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      write_bank     <= 1'b0;
      prev_ready     <= 1'b0;
    end else begin
      column_counter <= column_counter_next;
      write_bank     <= write_bank_next;
      prev_ready     <= prev_ready_next;
    end
  end

  // A flush that ends a row leaves no row buffered
  `RRI_ASSERT_NEXT(a_flush_drains_row, clk, rst,
    accept && (s_tuser == CMD_FLUSH) && prev_ready && last, !prev_ready,
    "flush at row end left a row buffered")

endmodule

/* design/rri_queue.sv */
// ---------------------------------------------------------------------------
// rri_queue
// Short first-in first-out buffer of classified items between the front
// end and the back end, so that each side can stall on its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "row_remap_linear_interp_macros.svh"

module rri_queue
  import rri_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  rri_item_t push_item,
  input  logic      pop,
  output logic      head_valid,
  output rri_item_t head_item,
  output logic      full
);

  rri_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_item  = entries[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `RRI_ASSERT_IMPLY(a_no_overflow, clk, rst, push, !full, "push into full queue")
  `RRI_ASSERT_IMPLY(a_no_underflow, clk, rst, pop, head_valid, "pop from empty queue")

endmodule

/* design/rri_back.sv */
// ---------------------------------------------------------------------------
// rri_back
// Executes queued items in order: map writes and reads, line store writes
// and paired neighbour reads, per-channel linear blend and the output
// register. Also clears the position map after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "row_remap_linear_interp_macros.svh"

module rri_back
  import rri_pkg::*;
#(
  parameter int ROW_CAPACITY  = ROW_CAPACITY_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int CNT_W         = $clog2(ROW_CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CNT_W-1:0]     eff_width,
  input  logic                 head_valid,
  input  rri_item_t            head_item,
  output logic                 pop,
  output logic                 clearing,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [7:0] out_blue, [15:8] out_green, [23:16] out_red, [35:24] out_column,
  // [39:36] zero
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam int COL_W   = $clog2(ROW_CAPACITY);
  localparam int F       = FRACTION_BITS;
  localparam int IP_W    = POSITION_W - F;
  localparam int CMP_W   = POSITION_W + 1;
  localparam int WEIGHT_W = F + 1;
  localparam int SUM_W   = CHANNEL_W + F + 2;

  typedef struct packed {
    logic                last;
    logic                black;
    logic                rbank;
    logic [COLUMN_W-1:0] col;
    logic [F-1:0]        frac;
  } rri_blend_t;

  // Linear blend of one channel with rounding
  function automatic logic [CHANNEL_W-1:0] blend(input logic [CHANNEL_W-1:0] a,
                                                 input logic [CHANNEL_W-1:0] b,
                                                 input logic [F-1:0] frac);
    logic [WEIGHT_W-1:0] wa;
    logic [SUM_W-1:0]    sum;
    wa  = (WEIGHT_W'(1) << F) - WEIGHT_W'(frac);
    sum = SUM_W'(a) * SUM_W'(wa) + SUM_W'(b) * SUM_W'(frac) + (SUM_W'(1) << (F - 1));
    return sum[F +: CHANNEL_W];
  endfunction

  logic                   adv;
  logic [COL_W-1:0]       clr_addr;

  logic [MAP_ENTRY_W-1:0] position_map [ROW_CAPACITY];
  logic [PIXEL_W-1:0]     line_store_a [ROW_CAPACITY];
  logic [PIXEL_W-1:0]     line_store_b [ROW_CAPACITY];

  logic                   map_we;
  logic [COL_W-1:0]       map_wa;
  logic [MAP_ENTRY_W-1:0] map_wd;
  logic [MAP_ENTRY_W-1:0] map_rd;

  logic                   s1_valid;
  rri_item_t              s1_item;

  logic                   map_vbit;
  logic [IP_W-1:0]        ip;
  logic [CMP_W-1:0]       ip_ext;
  logic [CMP_W-1:0]       w_ext;
  logic [CMP_W-1:0]       ip_next;
  logic [CMP_W-1:0]       i2;
  logic [COL_W-1:0]       addr0;
  logic [COL_W-1:0]       addr1;
  logic                   in_row;

  logic [PIXEL_W-1:0]     a_rd0;
  logic [PIXEL_W-1:0]     a_rd1;
  logic [PIXEL_W-1:0]     b_rd0;
  logic [PIXEL_W-1:0]     b_rd1;

  logic                   s2_valid;
  rri_blend_t             s2;
  logic [PIXEL_W-1:0]     p0;
  logic [PIXEL_W-1:0]     p1;
  logic [PIXEL_W-1:0]     blended;

  // The whole back end advances whenever the output register can take data
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && head_valid && !clearing;

  // Clear every map entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(ROW_CAPACITY - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Position map: one write port shared by clearing and loads, one read port
  assign map_we = clearing || (pop && head_item.map_wr);
  assign map_wa = clearing ? clr_addr : head_item.col[COL_W-1:0];
  assign map_wd = clearing ? '0 : head_item.map_entry;

  always_ff @(posedge clk) begin
    if (map_we) begin
      position_map[map_wa] <= map_wd;
    end
    if (adv) begin
      map_rd <= position_map[head_item.col[COL_W-1:0]];
    end
  end

  // Stage 1: item alongside its map entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= head_item;
    end
  end

  // Source position: integer part, fraction, clamped second neighbour
  assign map_vbit = map_rd[POSITION_W];
  assign ip       = map_rd[POSITION_W-1:F];
  assign ip_ext   = CMP_W'(ip);
  assign w_ext    = CMP_W'(eff_width);
  assign in_row   = ip_ext < w_ext;
  assign ip_next  = ip_ext + CMP_W'(1);
  assign i2       = (ip_next < w_ext) ? ip_next : (w_ext - CMP_W'(1));
  assign addr0    = ip_ext[COL_W-1:0];
  assign addr1    = i2[COL_W-1:0];

  // Line store A: pixel write, neighbour pair read
  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_item.store && !s1_item.bank) begin
      line_store_a[s1_item.col[COL_W-1:0]] <= s1_item.pixel;
    end
    if (adv) begin
      a_rd0 <= line_store_a[addr0];
      a_rd1 <= line_store_a[addr1];
    end
  end

  // Line store B: pixel write, neighbour pair read
  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_item.store && s1_item.bank) begin
      line_store_b[s1_item.col[COL_W-1:0]] <= s1_item.pixel;
    end
    if (adv) begin
      b_rd0 <= line_store_b[addr0];
      b_rd1 <= line_store_b[addr1];
    end
  end

  // Stage 2: only items that emit continue
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_item.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.last  <= s1_item.last;
      s2.black <= !map_vbit || !in_row;
      s2.rbank <= !s1_item.bank;
      s2.col   <= s1_item.col;
      s2.frac  <= map_rd[F-1:0];
    end
  end

  // Blend the neighbours from the bank holding the previous row
  assign p0 = s2.rbank ? b_rd0 : a_rd0;
  assign p1 = s2.rbank ? b_rd1 : a_rd1;

  always_comb begin
    blended[7:0]   = blend(p0[7:0],   p1[7:0],   s2.frac);
    blended[15:8]  = blend(p0[15:8],  p1[15:8],  s2.frac);
    blended[23:16] = blend(p0[23:16], p1[23:16], s2.frac);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      m_tdata <= {4'b0000, s2.col[OUT_COLUMN_W-1:0], s2.black ? '0 : blended};
      m_tlast <= s2.last;
    end
  end

  `RRI_ASSERT_IMPLY(a_no_item_while_clearing, clk, rst, clearing, !head_valid,
    "item queued during map clearing pass")

endmodule
